### hdl/mbba_pkg.sv
// mbba_pkg: shared widths, constants, codes and types of the multi-bank bump allocator
// no dependencies; used by the interfaces, the align unit and the top level

package mbba_pkg;

    // default bank count
    localparam int NUM_BANKS_DEF = 8;

    // field widths
    localparam int SIZE_W   = 20;
    localparam int ALOG_W   = 4;
    localparam int FILL_W   = 25;
    localparam int ALIGN_W  = 16;
    localparam int AL_W     = FILL_W + 1;
    localparam int END_W    = FILL_W + 2;
    localparam int OBANK_W  = 3;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;

    // constants
    localparam logic [FILL_W-1:0] FILL_MAX          = {FILL_W{1'b1}};
    localparam logic [SIZE_W-1:0] LARGE_ARRAY_BYTES = SIZE_W'(64);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;

    // strategy codes
    localparam logic [MODE_W-1:0] MODE_LINEAR      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INTERLEAVED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPTIMIZED   = 2'd2;

    // action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // register reset values
    localparam logic [MODE_W-1:0] MODE_RESET     = MODE_LINEAR;
    localparam logic [FILL_W-1:0] CAPACITY_RESET = FILL_W'(65536);

    // align unit result
    typedef struct packed {
        logic [AL_W-1:0]   al;
        logic [END_W-1:0]  end_sum;
        logic              fits;
        logic [FILL_W-1:0] free_sp;
    } align_res_t;

endpackage

### hdl/mbba_if.sv
// mbba_if: valid/ready channels for requests and results
// depends on mbba_pkg for payload widths

interface mbba_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [mbba_pkg::SIZE_W-1:0]   request_size;
    logic [mbba_pkg::ALOG_W-1:0]   align_log2;
    logic                          is_array;

    modport source (output valid, output action, output request_size,
                    output align_log2, output is_array, input ready);
    modport sink   (input valid, input action, input request_size,
                    input align_log2, input is_array, output ready);
endinterface

interface mbba_res_if;
    logic                          valid;
    logic                          ready;
    logic [mbba_pkg::OBANK_W-1:0]  bank_index;
    logic [mbba_pkg::FILL_W-1:0]   region_offset;
    logic                          aligned_flag;
    logic                          no_fit;

    modport source (output valid, output bank_index, output region_offset,
                    output aligned_flag, output no_fit, input ready);
    modport sink   (input valid, input bank_index, input region_offset,
                    input aligned_flag, input no_fit, output ready);
endinterface

### hdl/mbba_ram.sv
// mbba_ram: generic single-write, single-read ram with registered read data
// no dependencies

module mbba_ram #(
    parameter int WIDTH  = 25,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mbba_align_unit.sv
// mbba_align_unit: shared align, fit-check and free-space unit
// depends on mbba_pkg for widths and the result struct

module mbba_align_unit (
    input  logic [mbba_pkg::FILL_W-1:0] fill,
    input  logic [mbba_pkg::ALOG_W-1:0] align_log2,
    input  logic [mbba_pkg::SIZE_W-1:0] request_size,
    input  logic [mbba_pkg::FILL_W-1:0] capacity,
    output mbba_pkg::align_res_t        res
);

    logic [mbba_pkg::ALIGN_W-1:0] amask;
    logic [mbba_pkg::AL_W-1:0]    al;
    logic [mbba_pkg::END_W-1:0]   end_sum;

    // alignment mask is two to the power minus one
    assign amask = mbba_pkg::ALIGN_W'((17'(1) << align_log2) - 17'(1));

    // round the pointer up, then add the size
    assign al      = (mbba_pkg::AL_W'(fill) + mbba_pkg::AL_W'(amask))
                     & ~mbba_pkg::AL_W'(amask);
    assign end_sum = mbba_pkg::END_W'(al) + mbba_pkg::END_W'(request_size);

    always_comb
    begin
        res.al      = al;
        res.end_sum = end_sum;
        res.fits    = (end_sum <= mbba_pkg::END_W'(capacity));
        res.free_sp = capacity - fill;
    end

endmodule

### hdl/multi_bank_bump_allocator_unit.sv
// multi_bank_bump_allocator_unit: a scanned allocation passes through the scan, pick, update and
// done states, a large array sent to bank 0 in interleaved mode through fetch, update and done,
// and a clear goes straight to done; one request at a time, the next accepted the cycle after
// the result is loaded, with the scan reading one bank pointer per cycle through the single
// ram read port and the shared align unit.
// reset (rst_n low, asynchronous) zeroes all bank pointers through per-bank valid bits and
// loads strategy 0 and capacity 65536; no clearing pass is needed.

module multi_bank_bump_allocator_unit #(
    parameter int NUM_BANKS = mbba_pkg::NUM_BANKS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mbba_req_if.sink                          req,
    mbba_res_if.source                        res,
    input  logic                              cfg_we,
    input  logic [mbba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbba_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BANKS + 1);
    localparam int FILL_W = mbba_pkg::FILL_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_FETCH  = 6'b000100,
        ST_PICK   = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [mbba_pkg::MODE_W-1:0] mode_reg;
    logic [FILL_W-1:0]           cap_reg;

    // request registers
    logic [mbba_pkg::SIZE_W-1:0] size_reg;
    logic [mbba_pkg::ALOG_W-1:0] alog_reg;

    // scan registers
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              eval_vld_reg, eval_vld_next;
    logic [BANK_W-1:0] eval_idx_reg, eval_idx_next;
    logic [FILL_W-1:0] max_free_reg, max_free_next;
    logic [BANK_W-1:0] best_idx_reg, best_idx_next;
    logic [FILL_W-1:0] best_fill_reg, best_fill_next;
    logic [BANK_W-1:0] min_idx_reg, min_idx_next;
    logic [FILL_W-1:0] min_fill_reg, min_fill_next;
    logic [BANK_W-1:0] sel_bank_reg, sel_bank_next;
    logic [FILL_W-1:0] sel_fill_reg, sel_fill_next;

    // per-bank valid bits; an invalid bank reads as zero fill
    logic [NUM_BANKS-1:0] vld_reg, vld_next;

    // pending result
    logic [mbba_pkg::OBANK_W-1:0] pend_bank_reg, pend_bank_next;
    logic [FILL_W-1:0]            pend_off_reg, pend_off_next;
    logic                         pend_alf_reg, pend_alf_next;
    logic                         pend_nofit_reg, pend_nofit_next;

    // output register
    logic                         out_vld_reg, out_vld_next;
    logic [mbba_pkg::OBANK_W-1:0] out_bank_reg;
    logic [FILL_W-1:0]            out_off_reg;
    logic                         out_alf_reg;
    logic                         out_nofit_reg;
    logic                         out_load;

    // ram and align unit connections
    logic              ram_we;
    logic [BANK_W-1:0] ram_waddr;
    logic [FILL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BANK_W-1:0] ram_raddr;
    logic [FILL_W-1:0] ram_rdata;

    logic [FILL_W-1:0]    unit_fill;
    mbba_pkg::align_res_t unit_res;

    logic              req_xfer;
    logic              large_to_bank0;
    logic [FILL_W-1:0] eval_fill;
    logic [6:0]        sel_bank_wide;

    // saturate the new pointer
    function automatic logic [mbba_pkg::FILL_W-1:0] FILL_MAX_SAT(
        input logic [mbba_pkg::END_W-1:0] v
    );
        logic [mbba_pkg::FILL_W-1:0] r;
        r = (v > mbba_pkg::END_W'(mbba_pkg::FILL_MAX)) ? mbba_pkg::FILL_MAX
                                                        : v[mbba_pkg::FILL_W-1:0];
        return r;
    endfunction

    mbba_ram #(
        .WIDTH  (FILL_W),
        .DEPTH  (NUM_BANKS),
        .ADDR_W (BANK_W)
    ) u_fill_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mbba_align_unit u_align (
        .fill         (unit_fill),
        .align_log2   (alog_reg),
        .request_size (size_reg),
        .capacity     (cap_reg),
        .res          (unit_res)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;

    assign large_to_bank0 = (mode_reg == mbba_pkg::MODE_INTERLEAVED) && req.is_array
                            && (req.request_size > mbba_pkg::LARGE_ARRAY_BYTES);

    assign eval_fill = vld_reg[eval_idx_reg] ? ram_rdata : '0;
    assign unit_fill = (state_reg == ST_UPDATE) ? sel_fill_reg : eval_fill;

    assign sel_bank_wide = 7'(sel_bank_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mbba_pkg::MODE_RESET;
            cap_reg  <= mbba_pkg::CAPACITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbba_pkg::CFG_STRATEGY: mode_reg <= cfg_data[mbba_pkg::MODE_W-1:0];
                mbba_pkg::CFG_CAPACITY: cap_reg  <= cfg_data[FILL_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = eval_idx_reg;
        max_free_next   = max_free_reg;
        best_idx_next   = best_idx_reg;
        best_fill_next  = best_fill_reg;
        min_idx_next    = min_idx_reg;
        min_fill_next   = min_fill_reg;
        sel_bank_next   = sel_bank_reg;
        sel_fill_next   = sel_fill_reg;
        vld_next        = vld_reg;
        pend_bank_next  = pend_bank_reg;
        pend_off_next   = pend_off_reg;
        pend_alf_next   = pend_alf_reg;
        pend_nofit_next = pend_nofit_reg;
        ram_we          = 1'b0;
        ram_waddr       = sel_bank_reg;
        ram_wdata       = FILL_MAX_SAT(unit_res.end_sum);
        ram_re          = 1'b0;
        ram_raddr       = cnt_reg[BANK_W-1:0];
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req.action == mbba_pkg::ACT_CLEAR)
                    begin
                        vld_next        = '0;
                        pend_bank_next  = '0;
                        pend_off_next   = '0;
                        pend_alf_next   = 1'b0;
                        pend_nofit_next = 1'b0;
                        state_next      = ST_DONE;
                    end
                    else if (large_to_bank0)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        cnt_next      = '0;
                        max_free_next = '0;
                        best_idx_next = '0;
                        min_idx_next  = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle
                if (cnt_reg < CNT_W'(NUM_BANKS))
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = cnt_reg[BANK_W-1:0];
                    eval_vld_next = 1'b1;
                    eval_idx_next = cnt_reg[BANK_W-1:0];
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
                // evaluate the bank read last cycle
                if (eval_vld_reg)
                begin
                    if (unit_res.fits && (unit_res.free_sp > max_free_reg))
                    begin
                        max_free_next  = unit_res.free_sp;
                        best_idx_next  = eval_idx_reg;
                        best_fill_next = eval_fill;
                    end
                    if ((eval_idx_reg == '0) || (eval_fill < min_fill_reg))
                    begin
                        min_idx_next  = eval_idx_reg;
                        min_fill_next = eval_fill;
                    end
                    if (eval_idx_reg == BANK_W'(NUM_BANKS - 1))
                    begin
                        state_next = ST_PICK;
                    end
                end
            end

            ST_FETCH:
            begin
                sel_bank_next = '0;
                sel_fill_next = vld_reg[0] ? ram_rdata : '0;
                state_next    = ST_UPDATE;
            end

            ST_PICK:
            begin
                // fall back to the least-used bank when no bank both fits the request and has free space
                if (max_free_reg == '0)
                begin
                    sel_bank_next = min_idx_reg;
                    sel_fill_next = min_fill_reg;
                end
                else
                begin
                    sel_bank_next = best_idx_reg;
                    sel_fill_next = best_fill_reg;
                end
                state_next = ST_UPDATE;
            end

            ST_UPDATE:
            begin
                ram_we                 = 1'b1;
                vld_next[sel_bank_reg] = 1'b1;
                pend_bank_next         = sel_bank_wide[mbba_pkg::OBANK_W-1:0];
                pend_off_next          = (unit_res.al > mbba_pkg::AL_W'(mbba_pkg::FILL_MAX))
                                         ? mbba_pkg::FILL_MAX
                                         : unit_res.al[FILL_W-1:0];
                pend_alf_next          = (alog_reg != '0);
                pend_nofit_next        = !unit_res.fits;
                state_next             = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_vld_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            eval_vld_reg <= 1'b0;
            vld_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            eval_vld_reg <= eval_vld_next;
            vld_reg      <= vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            size_reg <= req.request_size;
            alog_reg <= req.align_log2;
        end
        eval_idx_reg   <= eval_idx_next;
        max_free_reg   <= max_free_next;
        best_idx_reg   <= best_idx_next;
        best_fill_reg  <= best_fill_next;
        min_idx_reg    <= min_idx_next;
        min_fill_reg   <= min_fill_next;
        sel_bank_reg   <= sel_bank_next;
        sel_fill_reg   <= sel_fill_next;
        pend_bank_reg  <= pend_bank_next;
        pend_off_reg   <= pend_off_next;
        pend_alf_reg   <= pend_alf_next;
        pend_nofit_reg <= pend_nofit_next;
        if (out_load)
        begin
            out_bank_reg  <= pend_bank_reg;
            out_off_reg   <= pend_off_reg;
            out_alf_reg   <= pend_alf_reg;
            out_nofit_reg <= pend_nofit_reg;
        end
    end

    assign res.valid         = out_vld_reg;
    assign res.bank_index    = out_bank_reg;
    assign res.region_offset = out_off_reg;
    assign res.aligned_flag  = out_alf_reg;
    assign res.no_fit        = out_nofit_reg;

    // a clear transfer invalidates every bank pointer
    a_clear_invalidates: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_xfer && (req.action == mbba_pkg::ACT_CLEAR)) |=> (vld_reg == '0)
    ) else $error("clear did not invalidate bank pointers");

    // an update leaves the chosen bank valid
    a_update_sets_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> vld_reg[$past(sel_bank_reg)]
    ) else $error("updated bank not marked valid");

    // scan counter stays within the bank count
    a_scan_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(NUM_BANKS))
    ) else $error("scan counter past bank count");

    // a new result is loaded only into a free or draining output register
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !res.ready) |-> !out_load
    ) else $error("result overwritten before transfer");

endmodule
